[hdl/dqs_pkg.sv]
// Shared constants and types for the double-ended queue with search.
package dqs_pkg;

  // Deque size and derived widths
  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned STS_W = 2;
  localparam int unsigned OCC_W = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

  // Status codes
  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  // Per-transfer control broadcast to every cell
  typedef struct packed {
    logic en;
    logic push_back;
    logic push_front;
    logic pop_back;
    logic pop_front;
    logic search;
  } dqs_ctrl_t;

endpackage

[hdl/dqs_cell.sv]
// One storage cell of the deque chain: holds a value, shifts with its neighbors.
module dqs_cell
  import dqs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dqs_ctrl_t        ctrl_i,
  input  logic [VAL_W-1:0] key_i,
  input  logic             first_i,
  input  logic             prev_valid_i,
  input  logic [VAL_W-1:0] prev_value_i,
  input  logic             next_valid_i,
  input  logic [VAL_W-1:0] next_value_i,
  output logic             valid_o,
  output logic [VAL_W-1:0] value_o,
  output logic             hit_o,
  output logic [VAL_W-1:0] pick_o
);

  logic             valid_q, valid_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic             hit_q, hit_d;
  logic [VAL_W-1:0] pick_q, pick_d;
  logic             tail;

  // This cell is the back of the queue when it holds a value and its successor is empty
  assign tail = valid_q & ~next_valid_i;

  // Shift, load or clear according to the command
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    hit_d   = hit_q;
    pick_d  = pick_q;
    if (ctrl_i.en) begin
      priority if (ctrl_i.push_front) begin
        valid_d = prev_valid_i;
        value_d = prev_value_i;
      end else if (ctrl_i.push_back) begin
        if (prev_valid_i && !valid_q) begin
          valid_d = 1'b1;
          value_d = key_i;
        end
      end else if (ctrl_i.pop_front) begin
        valid_d = next_valid_i;
        value_d = next_value_i;
      end else if (ctrl_i.pop_back) begin
        if (tail) begin
          valid_d = 1'b0;
        end
      end else begin
        // Search, refused command or no-op: hold the chain
      end
      // Capture per-cell search hit and popped value before the shift
      hit_d  = ctrl_i.search & valid_q & (value_q == key_i);
      pick_d = ((ctrl_i.pop_back & tail) | (ctrl_i.pop_front & first_i & valid_q))
               ? value_q : '0;
    end
  end

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    hit_q   <= hit_d;
    pick_q  <= pick_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign hit_o   = hit_q;
  assign pick_o  = pick_q;

endmodule

[hdl/double_ended_queue_with_search.sv]
// Top level of the double-ended queue with membership search.
//
// A bounded deque of DEPTH signed 32-bit values kept in a row of cells, front
// in cell 0. Every command (push back, push front, pop back, pop front, search)
// yields one result with status, found flag, popped value and new occupancy.
// A command accepted at one edge updates the whole cell chain at that edge,
// while each cell latches its own match and pop flags; at the first edge at
// which the output register is free, those flags are folded through an OR
// over all cells into the output register. One command per cycle is
// sustained while the output is not stalled. The input stalls only while
// the flag stage is held by a stalled output. No clearing pass is needed
// after reset.
module double_ended_queue_with_search
  import dqs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STS_W-1:0]        status_o,
  output logic                    found_o,
  output logic signed [VAL_W-1:0] popped_value_o,
  output logic [OCC_W-1:0]        occupancy_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             s1_valid_q;
  logic [STS_W-1:0] s1_status_q, s1_status_d;
  logic [CNT_W-1:0] s1_cnt_q;
  logic             out_valid_q;
  logic [STS_W-1:0] out_status_q;
  logic             out_found_q;
  logic [VAL_W-1:0] out_popped_q;
  logic [OCC_W-1:0] out_occ_q;

  logic             accept, out_free, full, empty;
  dqs_ctrl_t        ctrl;
  logic [VAL_W-1:0] key;

  logic             cell_valid [DEPTH];
  logic [VAL_W-1:0] cell_value [DEPTH];
  logic             cell_hit   [DEPTH];
  logic [VAL_W-1:0] cell_pick  [DEPTH];
  logic             found_red;
  logic [VAL_W-1:0] popped_red;

  // Handshake
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = s1_valid_q & ~out_free;
  assign accept     = in_valid_i & ~in_stall_o;

  assign full  = (cnt_q == CNT_W'(DEPTH));
  assign empty = (cnt_q == '0);
  assign key   = value_i;

  // Decode the command into chain control and status
  always_comb begin
    ctrl        = '0;
    ctrl.en     = accept;
    s1_status_d = ST_OK;
    cnt_d       = cnt_q;
    unique case (command_i)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (full) begin
          s1_status_d = ST_FULL;
        end else begin
          ctrl.push_back  = (command_i == CMD_PUSH_BACK);
          ctrl.push_front = (command_i == CMD_PUSH_FRONT);
          cnt_d           = cnt_q + CNT_W'(1);
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (empty) begin
          s1_status_d = ST_EMPTY;
        end else begin
          ctrl.pop_back  = (command_i == CMD_POP_BACK);
          ctrl.pop_front = (command_i == CMD_POP_FRONT);
          cnt_d          = cnt_q - CNT_W'(1);
        end
      end
      CMD_SEARCH: begin
        ctrl.search = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             pv, nv;
    logic [VAL_W-1:0] pval, nval;
    if (i == 0) begin : g_head
      assign pv   = 1'b1;
      assign pval = key;
    end else begin : g_mid
      assign pv   = cell_valid[i-1];
      assign pval = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nv   = 1'b0;
      assign nval = '0;
    end else begin : g_body
      assign nv   = cell_valid[i+1];
      assign nval = cell_value[i+1];
    end
    dqs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (key),
      .first_i      (i == 0),
      .prev_valid_i (pv),
      .prev_value_i (pval),
      .next_valid_i (nv),
      .next_value_i (nval),
      .valid_o      (cell_valid[i]),
      .value_o      (cell_value[i]),
      .hit_o        (cell_hit[i]),
      .pick_o       (cell_pick[i])
    );
  end

  // Fold the per-cell flags; at most one pick is nonzero
  always_comb begin
    found_red  = 1'b0;
    popped_red = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found_red  = found_red | cell_hit[i];
      popped_red = popped_red | cell_pick[i];
    end
  end

  // Control registers: count, flag stage, output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (out_free) begin
        s1_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= s1_status_d;
      s1_cnt_q    <= cnt_d;
    end
    if (out_free && s1_valid_q) begin
      out_status_q <= s1_status_q;
      out_found_q  <= found_red;
      out_popped_q <= popped_red;
      out_occ_q    <= OCC_W'(s1_cnt_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_o        = out_found_q;
  assign popped_value_o = out_popped_q;
  assign occupancy_o    = out_occ_q;

endmodule

[hdl/dqs_checker.sv]
// Port-level checker for the deque, bound to the top level.
module dqs_checker
  import dqs_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic [CMD_W-1:0]        command_i,
  input logic signed [VAL_W-1:0] value_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [STS_W-1:0]        status_o,
  input logic                    found_o,
  input logic signed [VAL_W-1:0] popped_value_o,
  input logic [OCC_W-1:0]        occupancy_o
);

  // A dropped push reports a full deque
  a_full_occ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> occupancy_o == OCC_W'(DEPTH))
    else $error("full status with occupancy below depth");

  // A refused pop reports an empty deque and no value
  a_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> occupancy_o == '0 && popped_value_o == '0)
    else $error("empty status with stored entries or a popped value");

  // A hit needs a successful command on a nonempty deque
  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == ST_OK && occupancy_o != '0)
    else $error("search hit on an empty deque");

  // Occupancy never reports more than the deque holds
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  // A stalled result holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(found_o)
    && $stable(popped_value_o) && $stable(occupancy_o))
    else $error("stalled result changed");

endmodule

bind double_ended_queue_with_search dqs_checker u_dqs_checker (.*);

[dv/tb_top.sv]
// Self-checking testbench for the double-ended queue with membership search.
module tb_top;
  import dqs_pkg::*;

  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned QUIET_FROM   = 170;
  localparam int unsigned QUIET_TO     = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Command codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_NOP_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_NOP_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NOP_C = 3'd7;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef struct {
    logic [STS_W-1:0]        status;
    logic                    found;
    logic signed [VAL_W-1:0] popped;
    logic [OCC_W-1:0]        occupancy;
  } deque_reply_t;

  // Shadow deque plus the replies it predicts, oldest first
  class deque_checker;
    logic signed [VAL_W-1:0] shadow_cells[$];
    deque_reply_t            pending_replies[$];
    int unsigned             errors;
    int unsigned             checked;
    int unsigned             dropped_pushes;
    int unsigned             refused_pops;
    int unsigned             search_hits;

    function new();
      errors         = 0;
      checked        = 0;
      dropped_pushes = 0;
      refused_pops   = 0;
      search_hits    = 0;
    endfunction

    function int unsigned fill_level();
      return shadow_cells.size();
    endfunction

    // Return one stored value; caller makes sure the deque is not empty
    function logic signed [VAL_W-1:0] any_stored();
      return shadow_cells[$urandom_range(shadow_cells.size() - 1)];
    endfunction

    // Apply one accepted command to the shadow deque and queue its reply
    function void note_command(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] val);
      deque_reply_t r;
      r.status = ST_OK;
      r.found  = 1'b0;
      r.popped = '0;
      case (cmd)
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (shadow_cells.size() >= DEPTH) begin
            r.status = ST_FULL;
            dropped_pushes++;
          end else if (cmd == CMD_PUSH_BACK) begin
            shadow_cells.push_back(val);
          end else begin
            shadow_cells.push_front(val);
          end
        end
        CMD_POP_BACK, CMD_POP_FRONT: begin
          if (shadow_cells.size() == 0) begin
            r.status = ST_EMPTY;
            refused_pops++;
          end else if (cmd == CMD_POP_BACK) begin
            r.popped = shadow_cells.pop_back();
          end else begin
            r.popped = shadow_cells.pop_front();
          end
        end
        CMD_SEARCH: begin
          foreach (shadow_cells[i])
            if (shadow_cells[i] == val) r.found = 1'b1;
          if (r.found) search_hits++;
        end
        default: ;
      endcase
      r.occupancy = OCC_W'(shadow_cells.size());
      pending_replies.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted reply with the oldest prediction
    task check_reply(logic [STS_W-1:0] status, logic found,
                     logic signed [VAL_W-1:0] popped, logic [OCC_W-1:0] occupancy);
      deque_reply_t want;
      if (pending_replies.size() == 0) begin
        report("reply with nothing outstanding");
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      if (status !== want.status)
        report($sformatf("reply %0d status %0d, want %0d", checked, status, want.status));
      if (found !== want.found)
        report($sformatf("reply %0d found %0b, want %0b", checked, found, want.found));
      if (popped !== want.popped)
        report($sformatf("reply %0d popped %0d, want %0d", checked, popped, want.popped));
      if (occupancy !== want.occupancy)
        report($sformatf("reply %0d occupancy %0d, want %0d",
                         checked, occupancy, want.occupancy));
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [CMD_W-1:0]        command_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [STS_W-1:0]        status_o;
  logic                    found_o;
  logic signed [VAL_W-1:0] popped_value_o;
  logic [OCC_W-1:0]        occupancy_o;

  deque_checker tracker;
  logic         quiet;
  int unsigned  items_sent;
  int unsigned  cycle_count;

  double_ended_queue_with_search DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_o        (found_o),
    .popped_value_o (popped_value_o),
    .occupancy_o    (occupancy_o)
  );

  // Free-running clock, period 8
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Stall the result side at random, except through the quiet stretch
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Check every reply transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_reply(status_o, found_o, popped_value_o, occupancy_o);
  end

  // Give up on a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("[double_ended_queue_with_search] ERROR");
    $finish;
  end

  // Drive one command and hold it until the transfer happens
  task automatic send(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] val);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_command(cmd, val);
    items_sent++;
    quiet <= (items_sent >= QUIET_FROM) && (items_sent < QUIET_TO);
  endtask

  // Mix extremes and repeats of stored values into mostly random data
  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return (tracker.fill_level() > 0) ? tracker.any_stored() : $urandom();
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] rand_push();
    return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
  endfunction

  function automatic logic [CMD_W-1:0] rand_pop();
    return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  // Push until full, then push a few more that must be dropped
  task automatic fill_up();
    while (tracker.fill_level() < DEPTH) send(rand_push(), rand_value());
    repeat ($urandom_range(3, 1)) send(rand_push(), rand_value());
  endtask

  // Pop until empty, then pop a few more that must be refused
  task automatic drain_out();
    while (tracker.fill_level() > 0) send(rand_pop(), $urandom());
    repeat ($urandom_range(2, 1)) send(rand_pop(), $urandom());
  endtask

  // Random mix of all commands; searches use a stored value as key half the time
  task automatic mixed_run();
    int unsigned pick;
    logic signed [VAL_W-1:0] key;
    repeat ($urandom_range(30, 10)) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        send(CMD_PUSH_BACK, rand_value());
      end else if (pick < 40) begin
        send(CMD_PUSH_FRONT, rand_value());
      end else if (pick < 55) begin
        send(CMD_POP_BACK, $urandom());
      end else if (pick < 70) begin
        send(CMD_POP_FRONT, $urandom());
      end else if (pick < 94) begin
        key = (tracker.fill_level() > 0 && $urandom_range(1)) ? tracker.any_stored()
                                                               : rand_value();
        send(CMD_SEARCH, key);
      end else begin
        send(CMD_W'($urandom_range(CMD_NOP_C, CMD_NOP_A)), $urandom());
      end
    end
  endtask

  initial begin
    int unsigned kind;
    int unsigned random_start;
    tracker     = new();
    items_sent  = 0;
    quiet       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    command_i   = CMD_PUSH_BACK;
    value_i     = '0;
    out_stall_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty deque: refused pops, safe search, no-op codes
    send(CMD_POP_BACK, $urandom());
    send(CMD_POP_FRONT, $urandom());
    send(CMD_SEARCH, '0);
    send(CMD_NOP_A, $urandom());
    send(CMD_NOP_B, $urandom());
    send(CMD_NOP_C, $urandom());
    // Pop the only entry from either end
    send(CMD_PUSH_BACK, VAL_MAX);
    send(CMD_POP_FRONT, $urandom());
    send(CMD_PUSH_FRONT, VAL_MIN);
    send(CMD_POP_BACK, $urandom());
    // Order across both ends, hits and misses on extremes
    send(CMD_PUSH_BACK, -1);
    send(CMD_PUSH_FRONT, '0);
    send(CMD_PUSH_BACK, VAL_MIN);
    send(CMD_SEARCH, -1);
    send(CMD_SEARCH, VAL_MAX);
    send(CMD_SEARCH, VAL_MIN);
    send(CMD_NOP_C, $urandom());
    send(CMD_POP_FRONT, $urandom());
    send(CMD_POP_BACK, $urandom());
    send(CMD_POP_BACK, $urandom());
    send(CMD_SEARCH, -1);

    // Random episodes; open with a fill so the full case comes early
    random_start = items_sent;
    fill_up();
    while (items_sent - random_start < RANDOM_ITEMS) begin
      kind = $urandom_range(3);
      case (kind)
        0:       fill_up();
        1:       drain_out();
        default: mixed_run();
      endcase
    end
    in_valid_i <= 1'b0;

    // Wait for outstanding replies, then watch for strays
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d commands, checked %0d replies, %0d mismatches.",
             items_sent, tracker.checked, tracker.errors);
    $display("Dropped pushes when full: %0d, refused pops when empty: %0d, search hits: %0d.",
             tracker.dropped_pushes, tracker.refused_pops, tracker.search_hits);
    if (tracker.errors == 0 && tracker.pending_replies.size() == 0) begin
      $display("[double_ended_queue_with_search] OK");
    end else begin
      $display("[double_ended_queue_with_search] ERROR");
    end
    $finish;
  end

endmodule
